// ===== rtl/core/burner_ignition_sequencer_unit_macros.svh =====
// Assertion macros for the burner ignition sequencer.
// Used by modules that include this header; relies on clk and rst in scope.
`ifndef BURNER_IGNITION_SEQUENCER_UNIT_MACROS_SVH
`define BURNER_IGNITION_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication
`define BIS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sequencer check failed");

// next-cycle implication
`define BIS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sequencer check failed");

`endif

// ===== rtl/core/bis_pkg.sv =====
// Package for the burner ignition sequencer: state codes, drive bit
// positions, register indexes and the phase decode. No dependencies.
package bis_pkg;

  localparam int unsigned DELAY_WIDTH_DEF = 16;
  localparam int unsigned DELAY_MAX_W     = 32;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned DRIVE_W         = 8;
  localparam int unsigned PHASE_W         = 4;

  localparam logic [2:0] DAMPER_OFF  = 3'd7;
  localparam logic [2:0] DAMPER_LOW  = 3'd6;
  localparam logic [2:0] DAMPER_FULL = 3'd0;

  // drive word bit positions
  localparam int unsigned B_MGV    = 0;
  localparam int unsigned B_PILOT  = 1;
  localparam int unsigned B_BURNER = 2;
  localparam int unsigned B_BLOWER = 3;
  localparam int unsigned B_CW     = 4;
  localparam int unsigned B_CCW    = 5;
  localparam int unsigned B_IGN    = 6;
  localparam int unsigned B_BUZ    = 7;

  // register indexes (word address)
  localparam logic [2:0] REG_PURGE_ON  = 3'd0;
  localparam logic [2:0] REG_PURGE_OFF = 3'd1;
  localparam logic [2:0] REG_PILOT     = 3'd2;
  localparam logic [2:0] REG_IGNITER   = 3'd3;
  localparam logic [2:0] REG_RECHECK   = 3'd4;
  localparam logic [2:0] REG_SETTLE    = 3'd5;

  localparam logic [15:0] RST_PURGE_ON  = 16'd2000;
  localparam logic [15:0] RST_PURGE_OFF = 16'd2000;
  localparam logic [15:0] RST_PILOT     = 16'd1000;
  localparam logic [15:0] RST_IGNITER   = 16'd500;
  localparam logic [15:0] RST_RECHECK   = 16'd50;
  localparam logic [15:0] RST_SETTLE    = 16'd100;

  localparam logic [3:0] PH_CHECKS  = 4'd0;
  localparam logic [3:0] PH_HOMING  = 4'd1;
  localparam logic [3:0] PH_WAITING = 4'd2;
  localparam logic [3:0] PH_PURGE   = 4'd3;
  localparam logic [3:0] PH_IGNITE  = 4'd4;
  localparam logic [3:0] PH_BURNING = 4'd5;
  localparam logic [3:0] PH_RUNNING = 4'd6;
  localparam logic [3:0] PH_CLOSING = 4'd7;
  localparam logic [3:0] PH_CLOSED  = 4'd8;

  typedef enum logic [4:0] {
    S_CHK_STOP, S_CHK_THI, S_CHK_TLO, S_CHK_GAS,
    S_WAIT_OFF, S_SETTLE, S_WAIT_D0, S_WAIT_START,
    S_WAIT_D100, S_BLOWER_ON, S_BLOWER_OFF, S_WAIT_D5,
    S_BLOWER2, S_CHECK_MGV, S_PILOT, S_IGNITER,
    S_WAIT_D100B, S_RUN, S_RUN_RECHECK, S_WAIT_DOFF,
    S_CLOSED, S_CLOSED_RECHECK
  } seq_state_t;

  // decision of one tick, handed from next-state logic to drive logic
  typedef struct packed {
    logic       go;
    seq_state_t target;
    logic       buz_wr;
    logic       buz_val;
    logic       force_close;
  } step_t;

  function automatic logic [PHASE_W-1:0] phase_of(input seq_state_t s);
    logic [PHASE_W-1:0] p;
    p = PH_CLOSED;
    case (s) inside
      [S_CHK_STOP:S_CHK_GAS]:      p = PH_CHECKS;
      [S_WAIT_OFF:S_WAIT_D0]:      p = PH_HOMING;
      S_WAIT_START:                p = PH_WAITING;
      [S_WAIT_D100:S_BLOWER_OFF]:  p = PH_PURGE;
      [S_WAIT_D5:S_IGNITER]:       p = PH_IGNITE;
      S_WAIT_D100B:                p = PH_BURNING;
      [S_RUN:S_RUN_RECHECK]:       p = PH_RUNNING;
      S_WAIT_DOFF:                 p = PH_CLOSING;
      default:                     p = PH_CLOSED;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/burner_ignition_sequencer_unit.sv =====
// Burner ignition sequencer top level: sequencer state, timers, APB registers
// and the output skid stage. Depends on bis_pkg and the assertion macro header.
// Latency: a result appears on m_tdata the cycle after its tick word is taken,
// later only while an earlier word still waits on m_tready.
// Throughput: one tick word per cycle; s_tready drops only while the skid word is held.
// Reset (rst, synchronous): sequencer to the stop check, timer and stop flags
// cleared, all drives off, registers to their defaults, output stage empty.
`include "burner_ignition_sequencer_unit_macros.svh"

module burner_ignition_sequencer_unit
  import bis_pkg::*;
#(
  parameter int unsigned DELAY_WIDTH = DELAY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] damper_code, [3] start_n, [4] stop_level, [5] stop_edge,
  // [6] temp_high, [7] temp_low, [8] gas_pressure_n, [15:9] zero
  input  logic [15:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] main_gas_valve, [1] pilot_valve, [2] burner_valve, [3] blower_on,
  // [4] damper_cw, [5] damper_ccw, [6] igniter, [7] buzzer_on,
  // [11:8] phase, [15:12] zero
  output logic [15:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------- registers
  logic [CFG_W-1:0] purge_on_ticks, purge_off_ticks, pilot_ticks;
  logic [CFG_W-1:0] igniter_ticks, recheck_ticks, settle_ticks;
  logic [2:0]       reg_idx;
  logic             reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      purge_on_ticks  <= RST_PURGE_ON;
      purge_off_ticks <= RST_PURGE_OFF;
      pilot_ticks     <= RST_PILOT;
      igniter_ticks   <= RST_IGNITER;
      recheck_ticks   <= RST_RECHECK;
      settle_ticks    <= RST_SETTLE;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_PURGE_ON:  purge_on_ticks  <= pwdata[CFG_W-1:0];
        REG_PURGE_OFF: purge_off_ticks <= pwdata[CFG_W-1:0];
        REG_PILOT:     pilot_ticks     <= pwdata[CFG_W-1:0];
        REG_IGNITER:   igniter_ticks   <= pwdata[CFG_W-1:0];
        REG_RECHECK:   recheck_ticks   <= pwdata[CFG_W-1:0];
        REG_SETTLE:    settle_ticks    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PURGE_ON:  prdata = 32'(purge_on_ticks);
      REG_PURGE_OFF: prdata = 32'(purge_off_ticks);
      REG_PILOT:     prdata = 32'(pilot_ticks);
      REG_IGNITER:   prdata = 32'(igniter_ticks);
      REG_RECHECK:   prdata = 32'(recheck_ticks);
      REG_SETTLE:    prdata = 32'(settle_ticks);
      default:       prdata = '0;
    endcase
  end

  // saturate a tick setting into the timer range
  function automatic logic [DELAY_WIDTH-1:0] sat(input logic [CFG_W-1:0] v);
    logic [DELAY_MAX_W-1:0] ext;
    ext = DELAY_MAX_W'(v);
    if ((ext >> DELAY_WIDTH) != '0) return '1;
    return ext[DELAY_WIDTH-1:0];
  endfunction

  // ---------------------------------------------------------------- input word
  logic [2:0] damper_code;
  logic       start_n, stop_level, stop_edge, temp_high, temp_low, gas_pressure_n;
  logic       in_acc;

  assign damper_code    = s_tdata[2:0];
  assign start_n        = s_tdata[3];
  assign stop_level     = s_tdata[4];
  assign stop_edge      = s_tdata[5];
  assign temp_high      = s_tdata[6];
  assign temp_low       = s_tdata[7];
  assign gas_pressure_n = s_tdata[8];

  // ---------------------------------------------------------------- sequencer
  seq_state_t             seq_state, seq_state_next;
  logic [DELAY_WIDTH-1:0] delay_count, delay_count_next, delay_dec;
  logic                   stop_armed, stop_armed_next;
  logic                   stop_pending, stop_pending_next;
  logic [DRIVE_W-1:0]     drive_outputs, drive_outputs_next;
  step_t                  step;
  logic                   done, boundary, pend_v;

  assign delay_dec = (delay_count != '0) ? delay_count - 1'b1 : delay_count;
  assign done      = (delay_dec == '0);

  // next state, timer and stop handling
  always_comb begin
    step             = '0;
    step.target      = seq_state;
    boundary         = 1'b1;
    delay_count_next = delay_count;
    pend_v           = stop_pending | (stop_edge & stop_armed);
    stop_armed_next  = stop_armed & ~stop_edge;

    case (seq_state)
      S_CHK_STOP: begin
        step.buz_wr  = 1'b1;
        step.buz_val = stop_level;
        step.go      = ~stop_level;
        step.target  = S_CHK_THI;
      end
      S_CHK_THI: begin
        step.buz_wr  = 1'b1;
        step.buz_val = temp_high;
        step.go      = ~temp_high;
        step.target  = S_CHK_TLO;
      end
      S_CHK_TLO: begin
        step.buz_wr  = 1'b1;
        step.buz_val = temp_low;
        step.go      = ~temp_low;
        step.target  = S_CHK_GAS;
      end
      S_CHK_GAS: begin
        step.buz_wr  = 1'b1;
        step.buz_val = ~gas_pressure_n;
        step.go      = gas_pressure_n;
        step.target  = (damper_code == DAMPER_OFF) ? S_SETTLE : S_WAIT_OFF;
      end
      S_WAIT_OFF: begin
        step.go     = (damper_code == DAMPER_OFF);
        step.target = S_SETTLE;
      end
      S_SETTLE: begin
        delay_count_next = delay_dec;
        boundary         = done;
        step.go          = done;
        step.target      = S_WAIT_D0;
      end
      S_WAIT_D0: begin
        step.go     = (damper_code == DAMPER_LOW);
        step.target = S_WAIT_START;
      end
      S_WAIT_START: begin
        step.go     = ~start_n;
        step.target = S_WAIT_D100;
      end
      S_WAIT_D100: begin
        step.go     = (damper_code == DAMPER_FULL);
        step.target = S_BLOWER_ON;
      end
      S_BLOWER_ON: begin
        delay_count_next = delay_dec;
        boundary         = done;
        step.go          = done;
        step.target      = S_BLOWER_OFF;
      end
      S_BLOWER_OFF: begin
        delay_count_next = delay_dec;
        boundary         = done;
        step.go          = done;
        step.target      = S_WAIT_D5;
      end
      S_WAIT_D5: begin
        step.go     = (damper_code == DAMPER_LOW);
        step.target = S_BLOWER2;
      end
      S_BLOWER2: begin
        step.go     = 1'b1;
        step.target = S_CHECK_MGV;
      end
      S_CHECK_MGV: begin
        step.go     = ~gas_pressure_n;
        step.target = S_PILOT;
      end
      S_PILOT: begin
        delay_count_next = delay_dec;
        boundary         = done;
        step.go          = done;
        step.target      = S_IGNITER;
      end
      S_IGNITER: begin
        delay_count_next = delay_dec;
        boundary         = done;
        step.go          = done;
        step.target      = S_WAIT_D100B;
      end
      S_WAIT_D100B: begin
        step.go     = (damper_code == DAMPER_FULL);
        step.target = S_RUN;
      end
      S_RUN: begin
        step.go     = temp_high;
        step.target = S_RUN_RECHECK;
      end
      S_RUN_RECHECK: begin
        delay_count_next = delay_dec;
        boundary         = done;
        step.go          = done;
        step.target      = temp_high ? S_WAIT_DOFF : S_RUN;
      end
      S_WAIT_DOFF: begin
        step.go     = (damper_code == DAMPER_OFF);
        step.target = S_CLOSED;
      end
      S_CLOSED: begin
        step.go     = ~temp_low;
        step.target = S_CLOSED_RECHECK;
      end
      S_CLOSED_RECHECK: begin
        delay_count_next = delay_dec;
        boundary         = done;
        step.go          = done;
        step.target      = ~temp_low ? S_WAIT_START : S_CLOSED;
      end
      default: begin
        // unused code: back to the start-up checks, no entry actions
        step.go     = 1'b1;
        step.target = S_CHK_STOP;
      end
    endcase

    // timer loads and arming on entry
    if (step.go) begin
      case (step.target)
        S_SETTLE:         delay_count_next = sat(settle_ticks);
        S_BLOWER_ON:      delay_count_next = sat(purge_on_ticks);
        S_BLOWER_OFF:     delay_count_next = sat(purge_off_ticks);
        S_PILOT:          delay_count_next = sat(pilot_ticks);
        S_IGNITER:        delay_count_next = sat(igniter_ticks);
        S_RUN_RECHECK:    delay_count_next = sat(recheck_ticks);
        S_CLOSED_RECHECK: delay_count_next = sat(recheck_ticks);
        S_WAIT_D100:      stop_armed_next  = 1'b1;
        default: ;
      endcase
    end

    seq_state_next    = step.go ? step.target : seq_state;
    stop_pending_next = pend_v;
    // a pending stop lands on the next step boundary
    if (pend_v && boundary) begin
      step.force_close  = 1'b1;
      stop_pending_next = 1'b0;
      seq_state_next    = S_WAIT_DOFF;
    end
  end

  // drive outputs
  always_comb begin
    drive_outputs_next = drive_outputs;
    if (step.buz_wr) drive_outputs_next[B_BUZ] = step.buz_val;
    if (step.go) begin
      case (step.target)
        S_WAIT_OFF:   drive_outputs_next[B_CCW] = 1'b1;
        S_SETTLE:     drive_outputs_next[B_CCW] = 1'b0;
        S_WAIT_D0:    drive_outputs_next[B_CW]  = 1'b1;
        S_WAIT_START: drive_outputs_next[B_CW]  = 1'b0;
        S_WAIT_D100:  drive_outputs_next[B_CW]  = 1'b1;
        S_BLOWER_ON: begin
          drive_outputs_next[B_CW]     = 1'b0;
          drive_outputs_next[B_BLOWER] = 1'b1;
        end
        S_BLOWER_OFF: drive_outputs_next[B_BLOWER] = 1'b0;
        S_WAIT_D5:    drive_outputs_next[B_CCW]    = 1'b1;
        S_BLOWER2: begin
          drive_outputs_next[B_CCW]    = 1'b0;
          drive_outputs_next[B_BLOWER] = 1'b1;
        end
        S_CHECK_MGV:  drive_outputs_next[B_MGV]   = 1'b1;
        S_PILOT:      drive_outputs_next[B_PILOT] = 1'b1;
        S_IGNITER:    drive_outputs_next[B_IGN]   = 1'b1;
        S_WAIT_D100B: begin
          drive_outputs_next[B_IGN]    = 1'b0;
          drive_outputs_next[B_BURNER] = 1'b1;
          drive_outputs_next[B_CW]     = 1'b1;
        end
        S_RUN:        drive_outputs_next[B_CW] = 1'b0;
        S_WAIT_DOFF: begin
          drive_outputs_next        = '0;
          drive_outputs_next[B_CCW] = 1'b1;
        end
        S_CLOSED:     drive_outputs_next[B_CCW] = 1'b0;
        default: ;
      endcase
    end
    if (step.force_close) begin
      drive_outputs_next        = '0;
      drive_outputs_next[B_CCW] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state     <= S_CHK_STOP;
      delay_count   <= '0;
      stop_armed    <= 1'b0;
      stop_pending  <= 1'b0;
      drive_outputs <= '0;
    end else if (in_acc) begin
      seq_state     <= seq_state_next;
      delay_count   <= delay_count_next;
      stop_armed    <= stop_armed_next;
      stop_pending  <= stop_pending_next;
      drive_outputs <= drive_outputs_next;
    end
  end

  // ---------------------------------------------------------------- output stage
  logic [15:0] result, out_data, skid_data;
  logic        out_valid, skid_valid;

  assign result   = {4'b0, phase_of(seq_state_next), drive_outputs_next};
  assign s_tready = ~skid_valid;
  assign in_acc   = s_tvalid & s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_acc) begin
      if (out_valid && !m_tready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (m_tready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (out_valid && !m_tready) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end else if (m_tready && skid_valid) begin
      out_data <= skid_data;
    end
  end

  // ---------------------------------------------------------------- checks
  `BIS_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  `BIS_ASSERT_NEXT(a_accept_gives_word, in_acc, m_tvalid)
  `BIS_ASSERT_NOW(a_burner_needs_gas, drive_outputs[B_BURNER],
    drive_outputs[B_MGV] && drive_outputs[B_PILOT])
  `BIS_ASSERT_NOW(a_damper_one_way, drive_outputs[B_CW], !drive_outputs[B_CCW])
  `BIS_ASSERT_NOW(a_pending_in_delay, stop_pending,
    seq_state == S_SETTLE || seq_state == S_BLOWER_ON ||
    seq_state == S_BLOWER_OFF || seq_state == S_PILOT ||
    seq_state == S_IGNITER || seq_state == S_RUN_RECHECK ||
    seq_state == S_CLOSED_RECHECK)

endmodule

// ===== sim/burner_ignition_sequencer_unit_test.sv =====
// Self-checking bench for burner_ignition_sequencer_unit: tick words in, drive words out,
// each result checked against a cycle-free model of the sequencer held in a scoreboard class.
// Depends on bis_pkg for state codes, drive bit positions, register indexes and phase codes.
module burner_ignition_sequencer_unit_test
  import bis_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int NOISE_PCT    = 10;
  localparam int TIMERS_SMALL = 0;
  localparam int TIMERS_ZERO  = 1;
  localparam int TIMERS_MAX   = 2;

  class ignition_tracker;
    seq_state_t                 st;
    logic [DELAY_WIDTH_DEF-1:0] ticks_left;
    bit                         armed;
    bit                         pending;
    logic [DRIVE_W-1:0]         drv;
    logic [CFG_W-1:0]           regs [6];
    logic [15:0]                due [$];
    int                         mism;
    string drive_names [8] = '{"main_gas_valve", "pilot_valve", "burner_valve", "blower_on",
                               "damper_cw", "damper_ccw", "igniter", "buzzer_on"};

    function new();
      st         = S_CHK_STOP;
      ticks_left = '0;
      armed      = 1'b0;
      pending    = 1'b0;
      drv        = '0;
      mism       = 0;
      regs = '{RST_PURGE_ON, RST_PURGE_OFF, RST_PILOT, RST_IGNITER, RST_RECHECK, RST_SETTLE};
    endfunction

    function void flag(string what, logic [15:0] want, logic [15:0] got);
      mism++;
      if (mism <= 10)
        $display("%0t mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    endfunction

    function void load(int r);
      longint unsigned lim;
      lim = (64'd1 << DELAY_WIDTH_DEF) - 1;
      ticks_left = (longint'(regs[r]) > lim) ? lim[DELAY_WIDTH_DEF-1:0] : regs[r];
    endfunction

    function bit timer_done();
      if (ticks_left != 0) ticks_left--;
      return ticks_left == 0;
    endfunction

    // entry actions take effect in the tick of the transition
    function void take(seq_state_t s);
      case (s)
        S_WAIT_OFF:   drv[B_CCW] = 1'b1;
        S_SETTLE: begin
          drv[B_CCW] = 1'b0;
          load(REG_SETTLE);
        end
        S_WAIT_D0:    drv[B_CW] = 1'b1;
        S_WAIT_START: drv[B_CW] = 1'b0;
        S_WAIT_D100: begin
          drv[B_CW] = 1'b1;
          armed = 1'b1;
        end
        S_BLOWER_ON: begin
          drv[B_CW] = 1'b0;
          drv[B_BLOWER] = 1'b1;
          load(REG_PURGE_ON);
        end
        S_BLOWER_OFF: begin
          drv[B_BLOWER] = 1'b0;
          load(REG_PURGE_OFF);
        end
        S_WAIT_D5:    drv[B_CCW] = 1'b1;
        S_BLOWER2: begin
          drv[B_CCW] = 1'b0;
          drv[B_BLOWER] = 1'b1;
        end
        S_CHECK_MGV:  drv[B_MGV] = 1'b1;
        S_PILOT: begin
          drv[B_PILOT] = 1'b1;
          load(REG_PILOT);
        end
        S_IGNITER: begin
          drv[B_IGN] = 1'b1;
          load(REG_IGNITER);
        end
        S_WAIT_D100B: begin
          drv[B_IGN] = 1'b0;
          drv[B_BURNER] = 1'b1;
          drv[B_CW] = 1'b1;
        end
        S_RUN:        drv[B_CW] = 1'b0;
        S_RUN_RECHECK, S_CLOSED_RECHECK: load(REG_RECHECK);
        S_WAIT_DOFF: begin
          drv = '0;
          drv[B_CCW] = 1'b1;
        end
        S_CLOSED:     drv[B_CCW] = 1'b0;
        default: ;
      endcase
      st = s;
    endfunction

    function logic [PHASE_W-1:0] shown_phase();
      case (st)
        S_CHK_STOP, S_CHK_THI, S_CHK_TLO, S_CHK_GAS:          return PH_CHECKS;
        S_WAIT_OFF, S_SETTLE, S_WAIT_D0:                      return PH_HOMING;
        S_WAIT_START:                                         return PH_WAITING;
        S_WAIT_D100, S_BLOWER_ON, S_BLOWER_OFF:               return PH_PURGE;
        S_WAIT_D5, S_BLOWER2, S_CHECK_MGV, S_PILOT, S_IGNITER: return PH_IGNITE;
        S_WAIT_D100B:                                         return PH_BURNING;
        S_RUN, S_RUN_RECHECK:                                 return PH_RUNNING;
        S_WAIT_DOFF:                                          return PH_CLOSING;
        default:                                              return PH_CLOSED;
      endcase
    endfunction

    function void note_tick(logic [15:0] w);
      logic [2:0] dmp;
      logic       st_n, s_lvl, s_edg, t_hi, t_lo, g_n;
      bit         bnd;
      {g_n, t_lo, t_hi, s_edg, s_lvl, st_n, dmp} = w[8:0];
      bnd = 1'b1;
      // an edge is only taken while armed; it waits for the next step boundary
      if (s_edg && armed) begin
        armed   = 1'b0;
        pending = 1'b1;
      end
      case (st)
        S_CHK_STOP: begin
          drv[B_BUZ] = s_lvl;
          if (!s_lvl) take(S_CHK_THI);
        end
        S_CHK_THI: begin
          drv[B_BUZ] = t_hi;
          if (!t_hi) take(S_CHK_TLO);
        end
        S_CHK_TLO: begin
          drv[B_BUZ] = t_lo;
          if (!t_lo) take(S_CHK_GAS);
        end
        S_CHK_GAS: begin
          drv[B_BUZ] = !g_n;
          if (g_n) take(dmp == DAMPER_OFF ? S_SETTLE : S_WAIT_OFF);
        end
        S_WAIT_OFF:   if (dmp == DAMPER_OFF) take(S_SETTLE);
        S_SETTLE: begin
          bnd = timer_done();
          if (bnd) take(S_WAIT_D0);
        end
        S_WAIT_D0:    if (dmp == DAMPER_LOW) take(S_WAIT_START);
        S_WAIT_START: if (!st_n) take(S_WAIT_D100);
        S_WAIT_D100:  if (dmp == DAMPER_FULL) take(S_BLOWER_ON);
        S_BLOWER_ON: begin
          bnd = timer_done();
          if (bnd) take(S_BLOWER_OFF);
        end
        S_BLOWER_OFF: begin
          bnd = timer_done();
          if (bnd) take(S_WAIT_D5);
        end
        S_WAIT_D5:    if (dmp == DAMPER_LOW) take(S_BLOWER2);
        S_BLOWER2:    take(S_CHECK_MGV);
        S_CHECK_MGV:  if (!g_n) take(S_PILOT);
        S_PILOT: begin
          bnd = timer_done();
          if (bnd) take(S_IGNITER);
        end
        S_IGNITER: begin
          bnd = timer_done();
          if (bnd) take(S_WAIT_D100B);
        end
        S_WAIT_D100B: if (dmp == DAMPER_FULL) take(S_RUN);
        S_RUN:        if (t_hi) take(S_RUN_RECHECK);
        S_RUN_RECHECK: begin
          bnd = timer_done();
          if (bnd) take(t_hi ? S_WAIT_DOFF : S_RUN);
        end
        S_WAIT_DOFF:  if (dmp == DAMPER_OFF) take(S_CLOSED);
        S_CLOSED:     if (!t_lo) take(S_CLOSED_RECHECK);
        S_CLOSED_RECHECK: begin
          bnd = timer_done();
          if (bnd) take(!t_lo ? S_WAIT_START : S_CLOSED);
        end
        default:      st = S_CHK_STOP;
      endcase
      if (pending && bnd) begin
        pending = 1'b0;
        take(S_WAIT_DOFF);
      end
      due.push_back({4'd0, shown_phase(), drv});
    endfunction

    function void check_outputs(logic [15:0] got);
      logic [15:0] want;
      if (due.size() == 0) begin
        flag("result word with nothing due", 16'hxxxx, got);
        return;
      end
      want = due.pop_front();
      for (int b = 0; b < DRIVE_W; b++)
        if (got[b] !== want[b]) flag(drive_names[b], 16'(want[b]), 16'(got[b]));
      if (got[11:8] !== want[11:8]) flag("phase", 16'(want[11:8]), 16'(got[11:8]));
      if (got[15:12] !== 4'd0) flag("pad bits", 16'd0, 16'(got[15:12]));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // [2:0] damper_code, [3] start_n, [4] stop_level, [5] stop_edge,
  // [6] temp_high, [7] temp_low, [8] gas_pressure_n, [15:9] zero
  logic [15:0] s_tdata = 16'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // [7:0] drive bits from main_gas_valve up to buzzer_on, [11:8] phase, [15:12] zero
  logic [15:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = 5'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  ignition_tracker burner = new();

  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int words_out     = 0;
  int hold_left     = 0;
  int cycles        = 0;

  burner_ignition_sequencer_unit i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("burner_ignition_sequencer_unit verification failed");
      $finish;
    end
  end

  // result side: check, then choose next ready; one long hold-off early on fills the block
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      burner.check_outputs(m_tdata);
      words_out++;
      if (words_out == 200) hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  function automatic logic [15:0] pack_tick(logic [2:0] dmp, logic st_n, logic s_lvl,
                                            logic s_edg, logic t_hi, logic t_lo, logic g_n);
    return {7'd0, g_n, t_lo, t_hi, s_edg, s_lvl, st_n, dmp};
  endfunction

  // mostly steers the sequencer forward from its current step, now and then pure noise
  function automatic logic [15:0] next_tick(int noise_pct);
    logic [2:0] dmp;
    logic       st_n, s_lvl, s_edg, t_hi, t_lo, g_n;
    dmp = 3'($urandom);
    {st_n, s_lvl, t_hi, t_lo, g_n} = 5'($urandom);
    s_edg = ($urandom_range(0, 99) < 2);
    if ($urandom_range(0, 99) >= noise_pct) begin
      case (burner.st)
        S_CHK_STOP:                dmp = dmp;
        S_WAIT_OFF, S_WAIT_DOFF:   dmp = DAMPER_OFF;
        S_WAIT_D0, S_WAIT_D5:      dmp = DAMPER_LOW;
        S_WAIT_D100, S_WAIT_D100B: dmp = DAMPER_FULL;
        S_WAIT_START:              st_n = 1'b0;
        S_CHECK_MGV:               g_n = 1'b0;
        S_RUN:                     t_hi = ($urandom_range(0, 3) == 0);
        S_RUN_RECHECK:             t_hi = ($urandom_range(0, 3) != 0);
        S_CLOSED, S_CLOSED_RECHECK: t_lo = ($urandom_range(0, 3) == 0);
        default: ;
      endcase
    end
    return pack_tick(dmp, st_n, s_lvl, s_edg, t_hi, t_lo, g_n);
  endfunction

  task automatic send_tick(input logic [15:0] w);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    burner.note_tick(w);
  endtask

  task automatic run_ticks(input int n);
    for (int k = 0; k < n; k++) send_tick(next_tick(NOISE_PCT));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (burner.due.size() != 0) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] idx, input logic [15:0] v,
                          output logic [31:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_timers();
    logic [31:0] rd;
    for (int i = int'(REG_PURGE_ON); i <= int'(REG_SETTLE); i++) begin
      apb_xfer(1'b0, 3'(i), 16'd0, rd);
      if (rd !== {16'd0, burner.regs[i]})
        burner.flag("register readback", burner.regs[i], rd[15:0]);
    end
  endtask

  task automatic load_timers(input int mode);
    logic [31:0] rd;
    logic [15:0] v;
    for (int i = int'(REG_PURGE_ON); i <= int'(REG_SETTLE); i++) begin
      case (mode)
        TIMERS_ZERO: v = 16'd0;
        TIMERS_MAX:  v = (i == int'(REG_RECHECK)) ? 16'($urandom_range(0, 4))
                                                   : 16'($urandom_range(40, 90));
        default:     v = 16'($urandom_range(0, 6));
      endcase
      apb_xfer(1'b1, 3'(i), v, rd);
      burner.regs[i] = v;
    end
    verify_timers();
  endtask

  initial begin
    logic [2:0] gas_dmp;
    int         n;
    bit         long_purge;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    verify_timers();

    // start-up checks with failing and passing inputs; the first edge on stop is not armed
    gas_dmp = $urandom_range(0, 1) ? DAMPER_OFF : DAMPER_FULL;
    send_tick(pack_tick(DAMPER_OFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    send_tick(pack_tick(DAMPER_FULL, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    send_tick(pack_tick(DAMPER_FULL, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));
    send_tick(pack_tick(DAMPER_LOW, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1));
    send_tick(pack_tick(DAMPER_LOW, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    send_tick(pack_tick(DAMPER_OFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    send_tick(pack_tick(DAMPER_OFF, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
    send_tick(pack_tick(DAMPER_OFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(pack_tick(gas_dmp, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_tick(pack_tick(DAMPER_LOW, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_tick(pack_tick(DAMPER_OFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    send_tick(pack_tick(DAMPER_FULL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    drain();

    // settle delay still counts down from its default here
    load_timers(TIMERS_SMALL);
    run_ticks(450);
    drain();

    snd_idle_pct = 63;
    load_timers(TIMERS_ZERO);
    run_ticks(400);
    drain();

    snd_idle_pct  = 0;
    rcv_stall_pct = 63;
    load_timers(TIMERS_SMALL);
    run_ticks(400);
    drain();

    // longer purge timers; stop once a blower run has ended and no timer is counting,
    // or when the tick budget for this phase is used up
    rcv_stall_pct = 0;
    load_timers(TIMERS_MAX);
    long_purge = 1'b0;
    n = 0;
    while (n < 240 && !(long_purge && !(burner.st inside {S_SETTLE, S_BLOWER_ON,
           S_BLOWER_OFF, S_PILOT, S_IGNITER, S_RUN_RECHECK, S_CLOSED_RECHECK}))) begin
      send_tick(next_tick(NOISE_PCT));
      if (burner.st == S_BLOWER_ON) long_purge = 1'b1;
      n++;
    end
    drain();

    snd_idle_pct  = 33;
    rcv_stall_pct = 33;
    load_timers(TIMERS_SMALL);
    run_ticks(450);
    drain();
    repeat (8) @(posedge clk);

    if (burner.mism == 0 && burner.due.size() == 0)
      $display("burner_ignition_sequencer_unit verification clean");
    else
      $display("burner_ignition_sequencer_unit verification failed");
    $finish;
  end

endmodule
